// ----- rtl/core/spq_pkg.sv -----
package spq_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int PRI_W    = 16;
    localparam int OCC_W    = 7;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_FIND   = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_POP    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_MISS  = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_EXEC
    } state_t;

    typedef struct packed {
        mode_t                    mode;
        logic signed [VAL_W-1:0]  item_value;
        logic        [PRI_W-1:0]  item_priority;
    } req_t;

    typedef struct packed {
        status_t                  status;
        logic signed [VAL_W-1:0]  out_value;
        logic        [PRI_W-1:0]  out_priority;
        logic        [OCC_W-1:0]  occupancy;
    } rsp_t;

    typedef struct packed {
        logic signed [VAL_W-1:0]  value;
        logic        [PRI_W-1:0]  pri;
    } entry_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic                     cmp_en;
        logic                     commit;
        mode_t                    mode;
        logic signed [VAL_W-1:0]  item_value;
        logic        [PRI_W-1:0]  item_priority;
    } cell_cmd_t;

    // search result gathered over the row
    typedef struct packed {
        logic                     hit;
        logic        [PRI_W-1:0]  pri;
        entry_t                   head;
    } search_t;

    // log-step prefix OR: bit i set when any bit at or below i is set
    function automatic logic [CAPACITY-1:0] prefix_or(input logic [CAPACITY-1:0] v);
        logic [CAPACITY-1:0] p;
        p = v;
        for (int s = 1; s < CAPACITY; s = s * 2) begin
            p = p | (p << s);
        end
        return p;
    endfunction

endpackage

// ----- rtl/core/sorted_priority_queue.sv -----
// Sorted priority queue of up to CAPACITY entries (signed 32-bit value, 16-bit
// priority), kept in ascending priority order with ties in arrival order.
// Issue a request by raising start while busy is low; req.mode selects insert,
// find, delete or pop. On acceptance every cell compares itself against the
// request in parallel; the controller then steps through ST_CMP, which only
// advances it, and ST_EXEC, which commits the shift along the cell row and
// registers the result. The result then sits on rsp with done high for
// exactly one cycle, during which busy is already low, so a new request may
// be accepted at the edge that ends it; no new request is taken while one is
// in flight. The receiver cannot stall: sample rsp whenever done is high.
// occupancy reports the entry count after the operation.
// Failed operations (insert when full, miss on find/delete, pop when empty)
// leave the store untouched and return zeros in the data fields.
module sorted_priority_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  spq_pkg::req_t  req,
    output logic           busy,
    output logic           done,
    output spq_pkg::rsp_t  rsp
);
    import spq_pkg::*;

    cell_cmd_t           cmd;
    search_t             search;
    logic [CNT_W-1:0]    count;
    entry_t              entries [CAPACITY];
    logic [CAPACITY-1:0] gt_vec;
    logic [CAPACITY-1:0] match_vec;
    logic [CAPACITY-1:0] after_vec;
    logic [CAPACITY-1:0] first_vec;
    logic [PRI_W-1:0]    pri_sel;

    // control: FSM, entry count and result register
    spq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .req    (req),
        .search (search),
        .busy   (busy),
        .cmd    (cmd),
        .count  (count),
        .done   (done),
        .rsp    (rsp)
    );

    // mark the first matching cell and every cell at or after it
    assign after_vec = prefix_or(match_vec);
    assign first_vec = match_vec & ~(after_vec << 1);

    // select the priority of the first match (one-hot OR)
    always_comb begin
        pri_sel = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            pri_sel = pri_sel | (first_vec[i] ? entries[i].pri : '0);
        end
    end

    assign search.hit  = |match_vec;
    assign search.pri  = pri_sel;
    assign search.head = entries[0];

    // the cell row: each cell hands its entry to a neighbor on commit
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        entry_t left_entry;
        entry_t right_entry;
        logic   left_gt;

        if (i == 0) begin : g_head
            assign left_entry = entries[i];
            assign left_gt    = 1'b0;
        end else begin : g_body
            assign left_entry = entries[i-1];
            assign left_gt    = gt_vec[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign right_entry = entries[i];
        end else begin : g_inner
            assign right_entry = entries[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .valid       (count > CNT_W'(i)),
            .at_end      (count == CNT_W'(i)),
            .after       (after_vec[i]),
            .left_entry  (left_entry),
            .left_gt     (left_gt),
            .right_entry (right_entry),
            .entry       (entries[i]),
            .gt          (gt_vec[i]),
            .match       (match_vec[i])
        );
    end

    // count never passes the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // a result strobe never repeats on the next cycle
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // accepted request raises busy until its result is out
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy ##1 busy ##1 (done && !busy))
        else $error("request did not complete in three cycles");

    // full status only when the store is at capacity
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status == STAT_FULL |-> count == CNT_W'(CAPACITY))
        else $error("full reported below capacity");

    // empty status only with an empty store
    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status == STAT_EMPTY |-> count == '0)
        else $error("empty reported with entries stored");

endmodule

// ----- rtl/core/spq_cell.sv -----
module spq_cell (
    input  logic               clk,
    input  spq_pkg::cell_cmd_t cmd,
    input  logic               valid,
    input  logic               at_end,
    input  logic               after,
    input  spq_pkg::entry_t    left_entry,
    input  logic               left_gt,
    input  spq_pkg::entry_t    right_entry,
    output spq_pkg::entry_t    entry,
    output logic               gt,
    output logic               match
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   gt_reg;
    logic   match_reg;

    // compare phase: flag entries that sort after the new one, and value hits
    always_ff @(posedge clk) begin
        if (cmd.cmp_en) begin
            gt_reg    <= valid && (entry_reg.pri > cmd.item_priority);
            match_reg <= valid && (entry_reg.value == cmd.item_value);
        end
        entry_reg <= entry_next;
    end

    always_comb begin
        entry_next = entry_reg;
        if (cmd.commit) begin
            case (cmd.mode)
                MODE_INSERT: begin
                    if (left_gt) begin
                        entry_next = left_entry;
                    end else if (gt_reg || at_end) begin
                        entry_next.value = cmd.item_value;
                        entry_next.pri   = cmd.item_priority;
                    end
                end
                MODE_DELETE: begin
                    if (after) begin
                        entry_next = right_entry;
                    end
                end
                MODE_POP: begin
                    entry_next = right_entry;
                end
                default: begin
                    entry_next = entry_reg;
                end
            endcase
        end
    end

    assign entry = entry_reg;
    assign gt    = gt_reg;
    assign match = match_reg;

endmodule

// ----- rtl/core/spq_ctrl.sv -----
module spq_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  spq_pkg::req_t              req,
    input  spq_pkg::search_t           search,
    output logic                       busy,
    output spq_pkg::cell_cmd_t         cmd,
    output logic [spq_pkg::CNT_W-1:0]  count,
    output logic                       done,
    output spq_pkg::rsp_t              rsp
);
    import spq_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              done_reg;
    logic              done_next;
    req_t              req_reg;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;
    logic              accept;
    logic              exec;
    logic              ok;
    status_t           status;

    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            req_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_CMP;
            ST_CMP:  state_next = ST_EXEC;
            ST_EXEC: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        busy = 1'b1;
        exec = 1'b0;
        case (state_reg)
            ST_IDLE: busy = 1'b0;
            ST_CMP:  busy = 1'b1;
            ST_EXEC: exec = 1'b1;
            default: busy = 1'b1;
        endcase
    end

    always_comb begin
        status = STAT_OK;
        case (req_reg.mode)
            MODE_INSERT: if (count_reg >= CNT_W'(CAPACITY)) status = STAT_FULL;
            MODE_FIND,
            MODE_DELETE: if (!search.hit) status = STAT_MISS;
            MODE_POP:    if (count_reg == '0) status = STAT_EMPTY;
            default:     status = STAT_OK;
        endcase
    end

    assign ok = (status == STAT_OK);

    always_comb begin
        count_next = count_reg;
        done_next  = exec;
        rsp_next   = rsp_reg;
        if (exec) begin
            if (ok) begin
                case (req_reg.mode)
                    MODE_INSERT: count_next = count_reg + 1'b1;
                    MODE_DELETE,
                    MODE_POP:    count_next = count_reg - 1'b1;
                    default:     count_next = count_reg;
                endcase
            end
            rsp_next.status       = status;
            rsp_next.out_value    = '0;
            rsp_next.out_priority = '0;
            if (ok && req_reg.mode == MODE_POP) begin
                rsp_next.out_value    = search.head.value;
                rsp_next.out_priority = search.head.pri;
            end else if (ok && (req_reg.mode == MODE_FIND || req_reg.mode == MODE_DELETE)) begin
                rsp_next.out_priority = search.pri;
            end
            rsp_next.occupancy = OCC_W'(count_next);
        end
    end

    assign cmd.cmp_en        = accept;
    assign cmd.commit        = exec && ok;
    assign cmd.mode          = exec ? req_reg.mode : req.mode;
    assign cmd.item_value    = accept ? req.item_value : req_reg.item_value;
    assign cmd.item_priority = accept ? req.item_priority : req_reg.item_priority;

    assign count = count_reg;
    assign done  = done_reg;
    assign rsp   = rsp_reg;

endmodule
